// ----- hw/rtl/marker_delimited_frame_splitter_top_assert.svh -----
// Assertion macros shared by the frame splitter checker.
// A file that uses them must have signals named clock and reset in scope.
`ifndef MARKER_DELIMITED_FRAME_SPLITTER_TOP_ASSERT_SVH
`define MARKER_DELIMITED_FRAME_SPLITTER_TOP_ASSERT_SVH

// Condition and consequence in the same cycle, switched off during reset.
`define MDFS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition, switched off during reset.
`define MDFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// State seen in the first cycle after reset has been released.
`define MDFS_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) $past(reset) |-> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/mdfs_pkg.sv -----
`timescale 1ns / 1ps
// Package for the marker delimited frame splitter: sizes, types, register
// indexes and the mark compare helpers. Depends on nothing.

package mdfs_pkg;

   localparam int MAX_MARK_BYTES = 8;
   localparam int LENGTH_BITS    = 16;
   localparam int HOLD_DEPTH     = MAX_MARK_BYTES + 1;
   localparam int MARK_BITS      = 8 * MAX_MARK_BYTES;
   localparam int FILL_BITS      = $clog2(HOLD_DEPTH + 1);

   localparam int REG_INDEX_BITS = 3;
   localparam int CSR_ADDR_BITS  = REG_INDEX_BITS + 3;
   localparam int CSR_DATA_BITS  = 64;

   typedef logic [7:0]                byte_type;
   typedef logic [MARK_BITS-1:0]      mark_type;
   typedef logic [FILL_BITS-1:0]      fill_type;
   typedef logic [LENGTH_BITS-1:0]    count_type;
   typedef logic [REG_INDEX_BITS-1:0] reg_index_type;

   localparam reg_index_type REG_BEGIN_MARK        = 3'd0;
   localparam reg_index_type REG_BEGIN_MARK_LENGTH = 3'd1;
   localparam reg_index_type REG_END_MARK          = 3'd2;
   localparam reg_index_type REG_END_MARK_LENGTH   = 3'd3;
   localparam reg_index_type REG_END_MARK_MODE     = 3'd4;
   localparam reg_index_type REG_FRAME_LENGTH      = 3'd5;
   localparam reg_index_type REG_KEEP_MARKS        = 3'd6;

   // A length of zero counts as one byte, anything beyond the window as all of it.
   function automatic fill_type mark_len(logic [3:0] raw);
      if (raw == 4'd0) begin
         return fill_type'(1);
      end else if (int'(raw) > MAX_MARK_BYTES) begin
         return fill_type'(MAX_MARK_BYTES);
      end else begin
         return fill_type'(raw);
      end
   endfunction

   // The newest len bytes of the window, oldest of them in the lowest lane.
   function automatic mark_type tail_bytes(mark_type win, fill_type len);
      int drop;
      drop = 8 * (MAX_MARK_BYTES - int'(len));
      return win >> drop;
   endfunction

   function automatic logic tail_match(mark_type win, fill_type fill, mark_type mark,
                                       fill_type len);
      int       drop;
      mark_type mask;
      drop = 8 * (MAX_MARK_BYTES - int'(len));
      mask = {MARK_BITS{1'b1}} >> drop;
      return (fill >= len) && ((win >> drop) == (mark & mask));
   endfunction

endpackage

// ----- hw/rtl/mdfs_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the frame splitter: the received byte
// stream and the frame word stream. Depends on mdfs_pkg.

interface mdfs_req_if;
   logic               valid;
   logic               ready;
   mdfs_pkg::byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mdfs_rsp_if;
   logic               valid;
   logic               ready;
   mdfs_pkg::byte_type frame_byte;
   logic               frame_first;
   logic               frame_last;

   modport source (output valid, output frame_byte, output frame_first, output frame_last,
                   input ready);
   modport sink   (input valid, input frame_byte, input frame_first, input frame_last,
                   output ready);
endinterface

// ----- hw/rtl/marker_delimited_frame_splitter_top.sv -----
`timescale 1ns / 1ps
// Top level of the marker delimited frame splitter: register port, framing
// logic and output word buffer. Depends on mdfs_pkg and mdfs_stream_if.
//
// The splitter takes one received byte per cycle into an input register while
// the output buffer has room and works on it there; each word passes the
// input register, then the output buffer. A byte releases between none and
// nine frame words, loaded together into a nine-entry output buffer that
// hands out one word per cycle while the receiver is ready; the next byte is
// taken in the cycle the buffer gives out its final word (or at once when it
// is empty). Bytes that release at most one word thus flow at one per cycle
// while the receiver is ready; a byte that releases more holds the input
// until the buffer has given them all out. Frames may be kept with or without
// their marks; the last byte of a frame is held back until the close is known
// so that it carries frame_last. Registers sit at byte address 8 * index on a
// 64-bit port and should only be written while no words are outstanding.

module marker_delimited_frame_splitter_top (
   input  logic                                clock,
   input  logic                                reset,
   mdfs_req_if.sink                            req_bus,
   mdfs_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mdfs_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mdfs_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mdfs_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   // Configuration registers
   mdfs_pkg::mark_type      begin_mark_ff;
   logic [3:0]              begin_len_ff;
   mdfs_pkg::mark_type      end_mark_ff;
   logic [3:0]              end_len_ff;
   logic                    end_mode_ff;
   logic [15:0]             frame_len_ff;
   logic                    keep_ff;

   logic                    csr_write;
   mdfs_pkg::reg_index_type csr_index;

   // Input register
   logic                    in_valid_ff;
   mdfs_pkg::byte_type      in_byte_ff;

   // Framing state
   mdfs_pkg::mark_type      win_ff;
   mdfs_pkg::mark_type      win_in;
   mdfs_pkg::fill_type      win_fill_ff;
   mdfs_pkg::fill_type      win_fill_in;
   logic                    inside_ff;
   logic                    inside_in;
   mdfs_pkg::byte_type      hold_ff [mdfs_pkg::HOLD_DEPTH];
   mdfs_pkg::byte_type      hold_in [mdfs_pkg::HOLD_DEPTH];
   mdfs_pkg::fill_type      hold_fill_ff;
   mdfs_pkg::fill_type      hold_fill_in;
   mdfs_pkg::count_type     count_ff;
   mdfs_pkg::count_type     count_in;
   logic                    first_pend_ff;
   logic                    first_pend_in;

   // Working values of the current byte
   mdfs_pkg::byte_type      hold_mid [mdfs_pkg::HOLD_DEPTH];
   mdfs_pkg::fill_type      n_emit;
   logic                    fp_mid;
   logic                    last_emit;

   // Output word buffer
   mdfs_pkg::byte_type      bat_ff [mdfs_pkg::HOLD_DEPTH];
   mdfs_pkg::byte_type      bat_in [mdfs_pkg::HOLD_DEPTH];
   mdfs_pkg::fill_type      bat_cnt_ff;
   mdfs_pkg::fill_type      bat_cnt_in;
   logic                    bat_first_ff;
   logic                    bat_first_in;
   logic                    bat_last_ff;
   logic                    bat_last_in;

   logic                    bat_free;
   logic                    process;
   logic                    pop;

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[mdfs_pkg::CSR_ADDR_BITS-1 -: mdfs_pkg::REG_INDEX_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         begin_mark_ff <= '0;
         begin_len_ff  <= 4'd1;
         end_mark_ff   <= '0;
         end_len_ff    <= 4'd1;
         end_mode_ff   <= 1'b1;
         frame_len_ff  <= '0;
         keep_ff       <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            mdfs_pkg::REG_BEGIN_MARK:        begin_mark_ff <= csr_pwdata;
            mdfs_pkg::REG_BEGIN_MARK_LENGTH: begin_len_ff  <= csr_pwdata[3:0];
            mdfs_pkg::REG_END_MARK:          end_mark_ff   <= csr_pwdata;
            mdfs_pkg::REG_END_MARK_LENGTH:   end_len_ff    <= csr_pwdata[3:0];
            mdfs_pkg::REG_END_MARK_MODE:     end_mode_ff   <= csr_pwdata[0];
            mdfs_pkg::REG_FRAME_LENGTH:      frame_len_ff  <= csr_pwdata[15:0];
            mdfs_pkg::REG_KEEP_MARKS:        keep_ff       <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         mdfs_pkg::REG_BEGIN_MARK:        csr_prdata = begin_mark_ff;
         mdfs_pkg::REG_BEGIN_MARK_LENGTH: csr_prdata = mdfs_pkg::CSR_DATA_BITS'(begin_len_ff);
         mdfs_pkg::REG_END_MARK:          csr_prdata = end_mark_ff;
         mdfs_pkg::REG_END_MARK_LENGTH:   csr_prdata = mdfs_pkg::CSR_DATA_BITS'(end_len_ff);
         mdfs_pkg::REG_END_MARK_MODE:     csr_prdata = mdfs_pkg::CSR_DATA_BITS'(end_mode_ff);
         mdfs_pkg::REG_FRAME_LENGTH:      csr_prdata = mdfs_pkg::CSR_DATA_BITS'(frame_len_ff);
         mdfs_pkg::REG_KEEP_MARKS:        csr_prdata = mdfs_pkg::CSR_DATA_BITS'(keep_ff);
         default:                         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake: the input register empties when its byte is processed,
   // which needs room in the word buffer for whatever it releases.
   // ------------------------------------------------------------------
   assign pop      = rsp_bus.valid && rsp_bus.ready;
   assign bat_free = (bat_cnt_ff == '0) ||
                     (rsp_bus.ready && bat_cnt_ff == mdfs_pkg::fill_type'(1));
   assign process  = in_valid_ff && bat_free;
   assign req_bus.ready = !in_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
      end
   end

   // ------------------------------------------------------------------
   // Framing logic for the byte in the input register
   // ------------------------------------------------------------------
   always_comb begin
      mdfs_pkg::fill_type  blen;
      mdfs_pkg::fill_type  elen;
      mdfs_pkg::fill_type  wf_step;
      mdfs_pkg::fill_type  fill_mid;
      mdfs_pkg::count_type count_mid;
      mdfs_pkg::count_type flen;
      mdfs_pkg::count_type excess;
      mdfs_pkg::mark_type  mark_bytes;
      logic                begin_hit;
      logic                end_hit;
      logic                opened;
      logic                active;
      logic                frame_close;
      logic                reopen;
      logic [mdfs_pkg::FILL_BITS:0] src;

      blen = mdfs_pkg::mark_len(begin_len_ff);
      elen = mdfs_pkg::mark_len(end_len_ff);
      flen = mdfs_pkg::count_type'(frame_len_ff);

      win_in  = {in_byte_ff, win_ff[mdfs_pkg::MARK_BITS-1:8]};
      wf_step = (win_fill_ff < mdfs_pkg::fill_type'(mdfs_pkg::MAX_MARK_BYTES)) ?
                win_fill_ff + 1'b1 : win_fill_ff;

      begin_hit  = mdfs_pkg::tail_match(win_in, wf_step, begin_mark_ff, blen);
      end_hit    = mdfs_pkg::tail_match(win_in, wf_step, end_mark_ff, elen);
      mark_bytes = mdfs_pkg::tail_bytes(win_in, blen);
      opened     = !inside_ff && begin_hit;
      active     = inside_ff || begin_hit;

      // First the byte joins the frame (or a frame opens with it).
      hold_mid  = hold_ff;
      fill_mid  = hold_fill_ff;
      count_mid = count_ff;
      fp_mid    = first_pend_ff;
      if (opened) begin
         for (int i = 0; i < mdfs_pkg::MAX_MARK_BYTES; i++) begin
            hold_mid[i] = mark_bytes[8*i +: 8];
         end
         fill_mid  = keep_ff ? blen : '0;
         count_mid = keep_ff ? mdfs_pkg::count_type'(blen) : '0;
         fp_mid    = 1'b1;
      end else if (inside_ff) begin
         if (hold_fill_ff >= mdfs_pkg::fill_type'(mdfs_pkg::HOLD_DEPTH)) begin
            for (int i = 0; i < mdfs_pkg::HOLD_DEPTH - 1; i++) begin
               hold_mid[i] = hold_ff[i+1];
            end
            hold_mid[mdfs_pkg::HOLD_DEPTH-1] = in_byte_ff;
            fill_mid = mdfs_pkg::fill_type'(mdfs_pkg::HOLD_DEPTH);
         end else begin
            for (int i = 0; i < mdfs_pkg::HOLD_DEPTH; i++) begin
               if (mdfs_pkg::fill_type'(i) == hold_fill_ff) begin
                  hold_mid[i] = in_byte_ff;
               end
            end
            fill_mid = hold_fill_ff + 1'b1;
         end
         count_mid = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      end

      // Then decide how many held bytes leave and whether the frame closes.
      frame_close = 1'b0;
      reopen      = 1'b0;
      n_emit      = '0;
      win_fill_in = opened ? '0 : wf_step;
      excess      = count_mid - flen;
      if (active) begin
         if (end_mode_ff) begin
            // Without kept marks the tail that may turn out to be the end
            // mark stays back.
            n_emit = keep_ff ? fill_mid : ((fill_mid > elen) ? fill_mid - elen : '0);
            if (!opened && end_hit) begin
               frame_close = 1'b1;
               win_fill_in = '0;
            end
         end else if (flen != '0) begin
            if (count_mid >= flen) begin
               frame_close = 1'b1;
               if (mdfs_pkg::count_type'(fill_mid) > excess) begin
                  n_emit = fill_mid - mdfs_pkg::fill_type'(excess);
               end else begin
                  n_emit = (fill_mid != '0) ? mdfs_pkg::fill_type'(1) : '0;
               end
               // Bytes beyond the length go back to the mark search.
               win_fill_in = fill_mid - n_emit;
            end else begin
               n_emit = fill_mid;
            end
         end else begin
            n_emit = (fill_mid > blen) ? fill_mid - blen : '0;
            if (!opened && begin_hit) begin
               frame_close = 1'b1;
               reopen      = 1'b1;
               win_fill_in = '0;
            end
         end
      end
      last_emit = frame_close && (n_emit != '0);

      // The bytes that leave are the front of the hold-back line.
      for (int i = 0; i < mdfs_pkg::HOLD_DEPTH; i++) begin
         src = (mdfs_pkg::FILL_BITS+1)'(i) + {1'b0, n_emit};
         if (src < (mdfs_pkg::FILL_BITS+1)'(mdfs_pkg::HOLD_DEPTH)) begin
            hold_in[i] = hold_mid[src[mdfs_pkg::FILL_BITS-1:0]];
         end else begin
            hold_in[i] = hold_mid[i];
         end
      end
      hold_fill_in  = fill_mid - n_emit;
      first_pend_in = fp_mid && (n_emit == '0);
      inside_in     = inside_ff || opened;
      count_in      = count_mid;

      if (frame_close) begin
         inside_in     = 1'b0;
         hold_fill_in  = '0;
         first_pend_in = 1'b0;
         count_in      = '0;
      end
      // A begin mark that closes a frame also opens the next one.
      if (reopen) begin
         for (int i = 0; i < mdfs_pkg::MAX_MARK_BYTES; i++) begin
            hold_in[i] = mark_bytes[8*i +: 8];
         end
         inside_in     = 1'b1;
         first_pend_in = 1'b1;
         hold_fill_in  = keep_ff ? blen : '0;
         count_in      = keep_ff ? mdfs_pkg::count_type'(blen) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff        <= '0;
         win_fill_ff   <= '0;
         inside_ff     <= 1'b0;
         hold_fill_ff  <= '0;
         count_ff      <= '0;
         first_pend_ff <= 1'b0;
      end else if (process) begin
         win_ff        <= win_in;
         win_fill_ff   <= win_fill_in;
         inside_ff     <= inside_in;
         hold_fill_ff  <= hold_fill_in;
         count_ff      <= count_in;
         first_pend_ff <= first_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         hold_ff <= hold_in;
      end
   end

   // ------------------------------------------------------------------
   // Output word buffer: loaded with every word a byte releases, then
   // shifted down one word per accepted output.
   // ------------------------------------------------------------------
   always_comb begin
      bat_in       = bat_ff;
      bat_cnt_in   = bat_cnt_ff;
      bat_first_in = bat_first_ff;
      bat_last_in  = bat_last_ff;
      if (process && n_emit != '0) begin
         bat_in       = hold_mid;
         bat_cnt_in   = n_emit;
         bat_first_in = fp_mid;
         bat_last_in  = last_emit;
      end else if (pop) begin
         for (int i = 0; i < mdfs_pkg::HOLD_DEPTH - 1; i++) begin
            bat_in[i] = bat_ff[i+1];
         end
         bat_cnt_in   = bat_cnt_ff - 1'b1;
         bat_first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bat_cnt_ff   <= '0;
         bat_first_ff <= 1'b0;
         bat_last_ff  <= 1'b0;
      end else begin
         bat_cnt_ff   <= bat_cnt_in;
         bat_first_ff <= bat_first_in;
         bat_last_ff  <= bat_last_in;
      end
   end

   always_ff @(posedge clock) begin
      bat_ff <= bat_in;
   end

   assign rsp_bus.valid       = (bat_cnt_ff != '0);
   assign rsp_bus.frame_byte  = bat_ff[0];
   assign rsp_bus.frame_first = bat_first_ff;
   assign rsp_bus.frame_last  = bat_last_ff && (bat_cnt_ff == mdfs_pkg::fill_type'(1));

endmodule

// ----- hw/rtl/mdfs_checker.sv -----
`timescale 1ns / 1ps
// Port checker for the frame splitter top level, bound to it below.
// Depends on mdfs_pkg and marker_delimited_frame_splitter_top_assert.svh.

`include "marker_delimited_frame_splitter_top_assert.svh"

module mdfs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mdfs_pkg::byte_type rsp_frame_byte,
   input logic               rsp_frame_first,
   input logic               rsp_frame_last
);

   // Set while the most recently delivered word closed its frame.
   logic after_last_ff;
   logic after_last_in;

   always_comb begin
      after_last_in = after_last_ff;
      if (rsp_valid && rsp_ready) begin
         after_last_in = rsp_frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_last_ff <= 1'b1;
      end else begin
         after_last_ff <= after_last_in;
      end
   end

   `MDFS_ASSERT_AFTER_RESET(a_reset_idle, !rsp_valid && req_ready,
      "splitter not empty and ready after reset")

   `MDFS_ASSERT_NOW(a_first_after_last, rsp_valid && after_last_ff, rsp_frame_first,
      "word after a closed frame does not open a frame")

   `MDFS_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_frame_first)
      && $stable(rsp_frame_last), "stalled frame word changed")

endmodule

bind marker_delimited_frame_splitter_top mdfs_checker u_mdfs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_frame_byte  (rsp_bus.frame_byte),
   .rsp_frame_first (rsp_bus.frame_first),
   .rsp_frame_last  (rsp_bus.frame_last)
);

// ----- tb/frame_splitter_checker.sv -----
`timescale 1ns / 1ps
// Checker for the frame splitter: follows register writes and taken bytes,
// predicts every frame word and compares it with the words that leave.
// Depends on mdfs_pkg and mdfs_stream_if.

module frame_splitter_checker
   import mdfs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   mdfs_req_if                      req_mon,
   mdfs_rsp_if                      rsp_mon,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       fail_count,
   output int                       pending_words
);

   localparam int COUNT_LIMIT = (1 << LENGTH_BITS) - 1;

   typedef struct packed {
      byte_type data;
      logic     first;
      logic     last;
   } frame_word_type;

   // Copies of the registers.
   mark_type        begin_mark_q;
   logic [3:0]      begin_len_q;
   mark_type        end_mark_q;
   logic [3:0]      end_len_q;
   logic            end_mode_q;
   logic [15:0]     frame_len_q;
   logic            keep_q;

   // Framing state, newest byte of the window in the top lane.
   mark_type        window;
   int              window_fill;
   bit              in_frame;
   byte_type        held [HOLD_DEPTH];
   int              held_fill;
   int              frame_count;
   bit              first_due;

   frame_word_type  expected_words [$];
   int              errors = 0;

   function automatic int mark_bytes(logic [3:0] raw);
      if (raw == 4'd0) return 1;
      if (int'(raw) > MAX_MARK_BYTES) return MAX_MARK_BYTES;
      return int'(raw);
   endfunction

   function automatic bit window_ends_with(int len, mark_type mark);
      mark_type mask;
      if (window_fill < len) return 1'b0;
      mask = (len >= MAX_MARK_BYTES) ? '1 : ((mark_type'(1) << (8 * len)) - 1);
      return (window >> (8 * (MAX_MARK_BYTES - len))) == (mark & mask);
   endfunction

   // When the hold-back store is full its oldest byte is dropped.
   function automatic void hold_byte(byte_type b);
      int i;
      if (held_fill >= HOLD_DEPTH) begin
         for (i = 0; i < HOLD_DEPTH - 1; i++) held[i] = held[i + 1];
         held_fill = HOLD_DEPTH - 1;
      end
      held[held_fill] = b;
      held_fill++;
   endfunction

   function automatic void release_front(bit last);
      frame_word_type w;
      int             i;
      w.data  = held[0];
      w.first = first_due;
      w.last  = last;
      for (i = 0; i < HOLD_DEPTH - 1; i++) held[i] = held[i + 1];
      held_fill--;
      first_due = 1'b0;
      expected_words.push_back(w);
   endfunction

   function automatic void release_down_to(int keep_held);
      while (held_fill > keep_held) release_front(1'b0);
   endfunction

   function automatic void close_frame(int count);
      int i;
      for (i = 0; i < count && held_fill > 0; i++) release_front(i + 1 == count);
      held_fill   = 0;
      in_frame    = 1'b0;
      first_due   = 1'b0;
      frame_count = 0;
   endfunction

   function automatic void open_frame(bit keep, int blen);
      int i;
      in_frame    = 1'b1;
      first_due   = 1'b1;
      held_fill   = 0;
      frame_count = 0;
      if (keep) begin
         for (i = 0; i < blen; i++) hold_byte(window[8 * (MAX_MARK_BYTES - blen + i) +: 8]);
         frame_count = blen;
      end
      window_fill = 0;
   endfunction

   function automatic void predict_byte(byte_type b);
      int blen, elen, flen, excess, k, left;
      bit keep, opened;
      blen   = mark_bytes(begin_len_q);
      elen   = mark_bytes(end_len_q);
      keep   = keep_q;
      flen   = int'(frame_len_q);
      opened = 1'b0;
      window = {b, window[MARK_BITS-1:8]};
      if (window_fill < MAX_MARK_BYTES) window_fill++;

      if (!in_frame) begin
         if (!window_ends_with(blen, begin_mark_q)) return;
         open_frame(keep, blen);
         opened = 1'b1;
      end else begin
         hold_byte(b);
         if (frame_count < COUNT_LIMIT) frame_count++;
      end

      if (end_mode_q) begin
         if (!opened && window_ends_with(elen, end_mark_q)) begin
            k = keep ? held_fill : (held_fill > elen ? held_fill - elen : 0);
            close_frame(k);
            window_fill = 0;
         end else begin
            release_down_to(keep ? 0 : elen);
         end
      end else if (flen != 0) begin
         if (frame_count >= flen) begin
            // Bytes past the length stay in the window and may start a mark.
            excess = frame_count - flen;
            k      = (held_fill > excess) ? held_fill - excess : (held_fill > 0 ? 1 : 0);
            left   = held_fill - k;
            close_frame(k);
            window_fill = left;
         end else begin
            release_down_to(0);
         end
      end else begin
         if (!opened && window_ends_with(blen, begin_mark_q)) begin
            k = (held_fill > blen) ? held_fill - blen : 0;
            close_frame(k);
            open_frame(keep, blen);
         end else begin
            release_down_to(blen);
         end
      end
   endfunction

   function automatic void reset_predictor();
      begin_mark_q = '0;
      begin_len_q  = 4'd1;
      end_mark_q   = '0;
      end_len_q    = 4'd1;
      end_mode_q   = 1'b1;
      frame_len_q  = '0;
      keep_q       = 1'b0;
      window       = '0;
      window_fill  = 0;
      in_frame     = 1'b0;
      held_fill    = 0;
      frame_count  = 0;
      first_due    = 1'b0;
      expected_words.delete();
   endfunction

   always @(posedge clock) begin : watch
      frame_word_type want;
      if (reset) begin
         reset_predictor();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected frame word: frame_byte %02h", rsp_mon.frame_byte);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.frame_byte !== want.data) begin
                  $error("frame_byte mismatch: expected %02h, actual %02h",
                         want.data, rsp_mon.frame_byte);
                  errors++;
               end
               if (rsp_mon.frame_first !== want.first) begin
                  $error("frame_first mismatch: expected %0b, actual %0b",
                         want.first, rsp_mon.frame_first);
                  errors++;
               end
               if (rsp_mon.frame_last !== want.last) begin
                  $error("frame_last mismatch: expected %0b, actual %0b",
                         want.last, rsp_mon.frame_last);
                  errors++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:3]))
               REG_BEGIN_MARK:        begin_mark_q = csr_pwdata;
               REG_BEGIN_MARK_LENGTH: begin_len_q  = csr_pwdata[3:0];
               REG_END_MARK:          end_mark_q   = csr_pwdata;
               REG_END_MARK_LENGTH:   end_len_q    = csr_pwdata[3:0];
               REG_END_MARK_MODE:     end_mode_q   = csr_pwdata[0];
               REG_FRAME_LENGTH:      frame_len_q  = csr_pwdata[15:0];
               REG_KEEP_MARKS:        keep_q       = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) predict_byte(req_mon.data_byte);
      end
      pending_words <= expected_words.size();
      fail_count    <= errors;
   end

endmodule

// ----- tb/tb_marker_delimited_frame_splitter_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the frame splitter: clock, reset, register writes and
// byte stimulus, random back-pressure and the verdict. Depends on mdfs_pkg,
// mdfs_stream_if, the splitter top and frame_splitter_checker.

module tb_marker_delimited_frame_splitter_top;
   import mdfs_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_BYTES   = 22;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;
   int                       fail_count;
   int                       pending_words;
   int                       sent_count = 0;
   bit                       sender_idles = 1'b1;

   mdfs_req_if req_bus ();
   mdfs_rsp_if rsp_bus ();

   marker_delimited_frame_splitter_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frame_splitter_checker u_frame_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Lengths of one and eight are sometimes written in their out-of-range forms.
   function automatic logic [3:0] encode_length(int len);
      if (len == 1 && $urandom_range(0, 2) == 0) return 4'd0;
      if (len == MAX_MARK_BYTES && $urandom_range(0, 1) == 1) return 4'($urandom_range(9, 15));
      return 4'(len);
   endfunction

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic send_byte(byte_type b);
      int gap;
      gap = sender_idles ? pick_gap() : 0;
      if ($urandom_range(0, 39) == 0) begin
         wait_drained();
      end else if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_mark(mark_type m, int n);
      int i;
      for (i = 0; i < n; i++) send_byte(m[8 * i +: 8]);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Held-back bytes give no word, so a quiet spell follows the last word.
   task automatic configure(mark_type bm, logic [3:0] bl, mark_type em, logic [3:0] el,
                            logic mode, logic [15:0] fl, logic keep);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_BEGIN_MARK, bm);
      csr_write(REG_BEGIN_MARK_LENGTH, 64'(bl));
      csr_write(REG_END_MARK, em);
      csr_write(REG_END_MARK_LENGTH, 64'(el));
      csr_write(REG_END_MARK_MODE, 64'(mode));
      csr_write(REG_FRAME_LENGTH, 64'(fl));
      csr_write(REG_KEEP_MARKS, 64'(keep));
   endtask

   task automatic run_random_phase(int p);
      mark_type    bm, em;
      int          blen, elen, n, i, target;
      logic        mode, keep;
      logic [15:0] fl;
      bm   = {$urandom, $urandom};
      em   = {$urandom, $urandom};
      blen = $urandom_range(1, MAX_MARK_BYTES);
      elen = $urandom_range(1, MAX_MARK_BYTES);
      mode = 1'($urandom_range(0, 1));
      keep = 1'($urandom_range(0, 1));
      fl   = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
      case (p)
         0: begin mode = 1'b1; blen = MAX_MARK_BYTES; elen = MAX_MARK_BYTES; keep = 1'b1; end
         1: begin mode = 1'b1; blen = 1; elen = 1; keep = 1'b0; end
         2: begin mode = 1'b0; fl = 16'd0; end
         3: begin mode = 1'b0; fl = 16'd1; keep = 1'b1; blen = MAX_MARK_BYTES; end
         4: begin mode = 1'b0; fl = 16'hFFFF; end
         default: ;
      endcase
      sender_idles = (p != 5);
      configure(bm, encode_length(blen), em, encode_length(elen), mode, fl, keep);
      target = sent_count + PHASE_BYTES;
      while (sent_count < target) begin
         n = $urandom_range(0, 9);
         if (n < 7) begin
            send_mark(bm, blen);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) send_byte(byte_type'($urandom_range(0, 255)));
            if (mode) send_mark(em, elen);
         end else if (n < 9) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) send_byte(byte_type'($urandom_range(0, 255)));
         end else begin
            // A begin mark cut short (whole when it is one byte), then a stray byte.
            send_mark(bm, (blen > 1) ? $urandom_range(1, blen - 1) : 1);
            send_byte(byte_type'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin : word_receiver
      int stall, run;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         run   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat (run) @(posedge clock);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || csr_psel) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int p;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // One-byte marks of zero: a one-byte frame, then an empty one.
      configure(64'h0, 4'd1, 64'h0, 4'd1, 1'b1, 16'd0, 1'b0);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h00);
      send_byte(8'h00); send_byte(8'h00);

      // Zero and out-of-range lengths; the end mark must not overlap the begin mark.
      configure(64'hA5, 4'd0, '1, 4'hF, 1'b1, 16'd0, 1'b1);
      send_mark(64'hA5, 1);
      send_mark('1, MAX_MARK_BYTES);

      // Fixed length shorter than a kept begin mark.
      configure(64'h030201, 4'd3, 64'h0, 4'd1, 1'b0, 16'd2, 1'b1);
      send_mark(64'h030201, 3);

      // Frames closed by the next begin mark; the last one stays open.
      configure(64'h55, 4'd1, 64'h0, 4'd1, 1'b0, 16'd0, 1'b0);
      send_byte(8'h55); send_byte(8'h10); send_byte(8'h20);
      send_byte(8'h55); send_byte(8'h30); send_byte(8'h55);

      for (p = 0; p < 7; p++) run_random_phase(p);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_words == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mdfs_pkg.sv
hw/rtl/mdfs_stream_if.sv
hw/rtl/marker_delimited_frame_splitter_top.sv
hw/rtl/mdfs_checker.sv
tb/frame_splitter_checker.sv
tb/tb_marker_delimited_frame_splitter_top.sv
